// ===== design/rafu_pkg.sv =====
// Package for the running average filter unit.
// Holds the sequencer state type, the divider status bundle and fixed constants.
// No dependencies.
package rafu_pkg;

	localparam int unsigned SAMPLE_W    = 32;
	localparam int unsigned WINDOW_W    = 6;
	localparam logic [WINDOW_W-1:0] WINDOW_RESET = 6'd20;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_START,
		ST_DIV,
		ST_HOLD
	} rafu_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} rafu_div_status_t;

endpackage

// ===== design/rafu_ring.sv =====
// Sample history memory for the running average filter unit.
// One write port and one read port with registered read data; depends on nothing.
module rafu_ring #(
	parameter int unsigned DEPTH = 32,
	parameter int unsigned WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/rafu_div.sv =====
// Serial signed-by-unsigned divider, one quotient bit per cycle.
// Truncates toward zero; uses the status bundle from rafu_pkg.
module rafu_div
	import rafu_pkg::*;
#(
	parameter int unsigned NW = 37,
	parameter int unsigned DW = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic signed [NW-1:0]  dividend,
	input  logic [DW-1:0]         divisor,
	output rafu_div_status_t      status,
	output logic signed [NW-1:0]  quotient
);

	localparam int unsigned CNT_W = $clog2(NW + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              neg_q;
	logic [NW-1:0]     mag_q;
	logic [DW-1:0]     rem_q;
	logic [DW-1:0]     dsr_q;
	logic [DW:0]       trial;
	logic              fits;
	logic [DW:0]       diff;

	assign trial = {rem_q, mag_q[NW-1]};
	assign fits  = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[NW-1];
			mag_q <= dividend[NW-1] ? NW'(-dividend) : NW'(dividend);
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
			mag_q <= {mag_q[NW-2:0], fits};
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient    = neg_q ? -signed'(mag_q) : signed'(mag_q);

endmodule

// ===== design/running_average_filter_unit.sv =====
// Channel   | Beat fields | Handshake
// sample    | sample      | sample_valid / sample_stall
// average   | average     | average_valid / average_stall
// config    | window_size | window_size_we (write only)
//
// After its sample beat, a result passes through the READ, START, DIV and HOLD states, and
// the unit takes no new sample beat before it is through with the last one.
// The serial divider produces one quotient bit per cycle.
// The input stalls from acceptance until the result is loaded into the output register.
// A finished result waits in the output register while the next sample is taken.
// Reset and any window_size write clear the sum, position and fill count.
//
// Top level of the running average filter unit.
// Depends on rafu_pkg, rafu_ring and rafu_div.
module running_average_filter_unit
	import rafu_pkg::*;
#(
	parameter int unsigned MAX_WINDOW = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        window_size_we,
	input  logic [WINDOW_W-1:0]         window_size,
	input  logic                        sample_valid,
	output logic                        sample_stall,
	input  logic signed [SAMPLE_W-1:0]  sample,
	output logic                        average_valid,
	input  logic                        average_stall,
	output logic signed [SAMPLE_W-1:0]  average
);

	localparam int unsigned PW = $clog2(MAX_WINDOW);
	localparam int unsigned CW = $clog2(MAX_WINDOW + 1);
	localparam int unsigned EW = (CW > WINDOW_W) ? CW : WINDOW_W;
	localparam int unsigned SW = SAMPLE_W + PW;

	rafu_state_t               state_q;
	rafu_state_t               state_d;
	logic [WINDOW_W-1:0]       window_q;
	logic signed [SW-1:0]      sum_q;
	logic [PW-1:0]             pos_q;
	logic [CW-1:0]             count_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic                      avg_valid_q;
	logic signed [SAMPLE_W-1:0] avg_q;

	logic [EW-1:0]             win_ext;
	logic [CW-1:0]             win;
	logic                      accept;
	logic                      ring_re;
	logic                      update_en;
	logic                      div_start;
	logic                      out_free;
	logic                      out_load;
	logic [SAMPLE_W-1:0]       ring_rdata;
	logic signed [SAMPLE_W-1:0] old_val;
	logic [CW-1:0]             pos_inc;
	logic                      not_full;
	rafu_div_status_t          div_status;
	logic signed [SW-1:0]      quotient;

	always_comb begin
		win_ext = EW'(window_q);
		if (win_ext == '0) begin
			win = CW'(1);
		end else if (win_ext > EW'(MAX_WINDOW)) begin
			win = CW'(MAX_WINDOW);
		end else begin
			win = CW'(win_ext);
		end
	end

	assign accept   = sample_valid && !sample_stall;
	assign out_free = !avg_valid_q || !average_stall;
	assign not_full = count_q < win;
	assign old_val  = not_full ? '0 : signed'(ring_rdata);
	assign pos_inc  = CW'(pos_q) + CW'(1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (sample_valid) begin
					state_d = ST_READ;
				end
			end
			ST_READ:  state_d = ST_START;
			ST_START: state_d = ST_DIV;
			ST_DIV: begin
				if (div_status.done) begin
					state_d = ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		sample_stall = 1'b1;
		ring_re      = 1'b0;
		update_en    = 1'b0;
		div_start    = 1'b0;
		out_load     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				sample_stall = 1'b0;
				ring_re      = 1'b1;
			end
			ST_READ:  update_en = 1'b1;
			ST_START: div_start = 1'b1;
			ST_DIV:   ;
			ST_HOLD:  out_load  = out_free;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			window_q    <= WINDOW_RESET;
			sum_q       <= '0;
			pos_q       <= '0;
			count_q     <= '0;
			avg_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (window_size_we) begin
				window_q <= window_size;
				sum_q    <= '0;
				pos_q    <= '0;
				count_q  <= '0;
			end else if (update_en) begin
				sum_q   <= sum_q - SW'(old_val) + SW'(sample_q);
				pos_q   <= (pos_inc >= win) ? '0 : PW'(pos_inc);
				count_q <= not_full ? count_q + CW'(1) : win;
			end
			if (out_load) begin
				avg_valid_q <= 1'b1;
			end else if (!average_stall) begin
				avg_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= sample;
		end
		if (out_load) begin
			avg_q <= quotient[SAMPLE_W-1:0];
		end
	end

	rafu_ring #(
		.DEPTH(MAX_WINDOW),
		.WIDTH(SAMPLE_W)
	) u_ring (
		.clk  (clk),
		.we   (update_en),
		.waddr(pos_q),
		.wdata(sample_q),
		.re   (ring_re),
		.raddr(pos_q),
		.rdata(ring_rdata)
	);

	rafu_div #(
		.NW(SW),
		.DW(CW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(sum_q),
		.divisor (count_q),
		.status  (div_status),
		.quotient(quotient)
	);

	assign average_valid = avg_valid_q;
	assign average       = avg_q;

endmodule

// ===== design/rafu_checker.sv =====
// Port-level checks for the running average filter unit, bound to its top level.
// Depends on rafu_pkg for field widths.
module rafu_checker
	import rafu_pkg::*;
(
	input logic                        clk,
	input logic                        arst_n,
	input logic                        sample_valid,
	input logic                        sample_stall,
	input logic signed [SAMPLE_W-1:0]  sample,
	input logic                        average_valid,
	input logic                        average_stall,
	input logic signed [SAMPLE_W-1:0]  average
);

	logic sample_beat;

	assign sample_beat = sample_valid && !sample_stall;

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_stall |=> sample_valid && $stable(sample))
		else $error("Stalled sample beat changed or dropped.");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		average_valid && average_stall |=> average_valid && $stable(average))
		else $error("Stalled average beat changed or dropped.");

	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		sample_beat |=> sample_stall)
		else $error("Sample taken while the previous one is still in work.");

	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		sample_beat |-> ##1 !$rose(average_valid) ##1 !$rose(average_valid))
		else $error("Result appeared too soon after a sample beat.");

	a_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(average_valid) |-> $past(sample_stall))
		else $error("New result appeared while no sample was in work.");

endmodule

bind running_average_filter_unit rafu_checker u_rafu_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample_valid),
	.sample_stall (sample_stall),
	.sample       (sample),
	.average_valid(average_valid),
	.average_stall(average_stall),
	.average      (average)
);
